FILE: hw/rtl/huff8_pkg.sv
// Shared types and constants for the 8-bit Huffman tree build and decode unit.
package huff8_pkg;

  // Tree entry format: bit 9 marks a branch, bits 8..0 hold the right-child index.
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned ENTRY_W    = 10;
  localparam int unsigned BRANCH_BIT = 9;
  localparam int unsigned SYM_W      = 8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DESC  = 2'd1,
    OP_LEAF  = 2'd2,
    OP_CODE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_DESC  = 3'd1,
    PH_LEAF  = 3'd2,
    PH_TERM  = 3'd3,
    PH_CODE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_TERM   = 3'd1,
    ERR_TABLE  = 3'd2,
    ERR_STACK  = 3'd3,
    ERR_KIND   = 3'd4,
    ERR_NOTREE = 3'd5
  } err_t;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] push_idx;
  } stk_ctl_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [IDX_W-1:0] top;
  } stk_stat_t;

endpackage

FILE: hw/rtl/huffman8_tree_build_and_decode_unit.sv
// Top level: builds a flat 8-bit Huffman tree and decodes code bits against it.
//
//  channel | direction | words
//  in_     | input     | operation, bit_value, byte_value
//  out_    | output    | symbol_valid, symbol, bit_consumed, expect_res, error_code
//
//  One input word per cycle while out_stall is low; each word's result reaches
//  the out_ ports through the input register, then the result register.
//  For each code bit the current node and both its children are held in
//  registers, the children read through the two read ports of the tree store.
//  Reset clears the phase, counters, stack depth and handshake state, not the tree
//  store or stack words. out_stall holds the result and backs up into in_stall.
module huffman8_tree_build_and_decode_unit #(
  parameter int unsigned TABLE_ENTRIES = 511,
  parameter int unsigned STACK_DEPTH   = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic       in_bit_value,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_symbol_valid,
  output logic [7:0] out_symbol,
  output logic       out_bit_consumed,
  output logic [2:0] out_expect_res,
  output logic [2:0] out_error_code
);
  import huff8_pkg::*;

  localparam int unsigned ECW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned TAW = $clog2(TABLE_ENTRIES);

  // input register
  logic             inq_valid_r;
  op_t              inq_op_r;
  logic             inq_bit_r;
  logic [SYM_W-1:0] inq_byte_r;

  logic adv;
  logic step;
  logic in_acc;

  // build and decode state
  phase_t             phase_r, phase_nxt;
  logic [ECW-1:0]     entry_cnt_r, entry_cnt_nxt;
  logic [ECW-1:0]     ent_inc;
  logic               tbl_full;
  logic [IDX_W-1:0]   walk_r, walk_nxt;
  logic [ENTRY_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0]   addr_a_r, addr_a_nxt;
  logic [IDX_W-1:0]   addr_b_r, addr_b_nxt;
  logic [ENTRY_W-1:0] lchild_r, rchild_r;
  logic [ENTRY_W-1:0] root_r;

  // decode step
  logic [IDX_W-1:0]   dec_walk;
  logic [ENTRY_W-1:0] dec_entry;
  logic               dec_used;

  // tree store
  logic [ENTRY_W-1:0] tree_mem [TABLE_ENTRIES];
  logic               mem_we;
  logic [TAW-1:0]     mem_wa;
  logic [ENTRY_W-1:0] mem_wd;
  logic               rng_a, rng_b;

  // deferred branch write
  logic               pend_valid_r, pend_valid_nxt;
  logic [TAW-1:0]     pend_addr_r;
  logic [ENTRY_W-1:0] pend_data_r;
  logic               pend_set;

  // step actions and result
  logic             leaf_wr, start_wr;
  err_t             err;
  logic             sym_valid;
  logic [SYM_W-1:0] sym;
  logic             used;

  stk_ctl_t  stk_ctl;
  stk_stat_t stk_stat;

  // result register
  logic             out_valid_r;
  logic             out_sym_valid_r;
  logic [SYM_W-1:0] out_sym_r;
  logic             out_used_r;
  phase_t           out_phase_r;
  err_t             out_err_r;

  assign adv      = !out_valid_r || !out_stall;
  assign step     = inq_valid_r && adv;
  assign in_stall = inq_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign tbl_full = (entry_cnt_r >= ECW'(TABLE_ENTRIES));
  assign ent_inc  = entry_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_acc) begin
      inq_valid_r <= 1'b1;
    end else if (step) begin
      inq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      inq_op_r   <= op_t'(in_operation);
      inq_bit_r  <= in_bit_value;
      inq_byte_r <= in_byte_value;
    end
  end

  huff8_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .stat  (stk_stat)
  );

  // One level of the walk: a branch takes the chosen child, a leaf stays put.
  always_comb begin
    if (cur_r[BRANCH_BIT]) begin
      dec_used  = 1'b1;
      dec_walk  = inq_bit_r ? cur_r[IDX_W-1:0] : walk_r + 1'b1;
      dec_entry = inq_bit_r ? rchild_r : lchild_r;
    end else begin
      dec_used  = 1'b0;
      dec_walk  = walk_r;
      dec_entry = cur_r;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      if (inq_op_r == OP_START) begin
        phase_nxt = inq_bit_r ? PH_DESC : PH_TERM;
      end else begin
        unique case (phase_r)
          PH_START, PH_CODE: begin
            phase_nxt = phase_r;
          end
          PH_DESC: begin
            priority if (inq_op_r != OP_DESC) begin
              phase_nxt = PH_START;
            end else if (!inq_bit_r) begin
              phase_nxt = PH_LEAF;
            end else if (tbl_full || stk_stat.full) begin
              phase_nxt = PH_START;
            end else begin
              phase_nxt = PH_DESC;
            end
          end
          PH_LEAF: begin
            priority if (inq_op_r != OP_LEAF || tbl_full) begin
              phase_nxt = PH_START;
            end else if (!stk_stat.empty) begin
              phase_nxt = PH_DESC;
            end else begin
              phase_nxt = PH_TERM;
            end
          end
          default: begin
            if (inq_op_r != OP_DESC || inq_bit_r) begin
              phase_nxt = PH_START;
            end else begin
              phase_nxt = PH_CODE;
            end
          end
        endcase
      end
    end
  end

  // step actions and result fields
  always_comb begin
    err           = ERR_NONE;
    sym_valid     = 1'b0;
    sym           = '0;
    used          = 1'b0;
    leaf_wr       = 1'b0;
    start_wr      = 1'b0;
    pend_set      = 1'b0;
    stk_ctl       = '0;
    stk_ctl.push_idx = IDX_W'(entry_cnt_r);
    entry_cnt_nxt = entry_cnt_r;
    walk_nxt      = walk_r;
    cur_nxt       = cur_r;
    addr_a_nxt    = addr_a_r;
    addr_b_nxt    = addr_b_r;
    if (step) begin
      if (inq_op_r == OP_START) begin
        entry_cnt_nxt = '0;
        stk_ctl.clear = 1'b1;
        walk_nxt      = '0;
        start_wr      = !inq_bit_r;
      end else begin
        unique case (phase_r)
          PH_START: begin
            err = (inq_op_r == OP_CODE) ? ERR_NOTREE : ERR_KIND;
          end
          PH_CODE: begin
            if (inq_op_r != OP_CODE) begin
              err = ERR_KIND;
            end else begin
              used = dec_used;
              if (!dec_entry[BRANCH_BIT]) begin
                // emit and return to the root
                sym_valid  = 1'b1;
                sym        = dec_entry[SYM_W-1:0];
                walk_nxt   = '0;
                cur_nxt    = root_r;
                addr_a_nxt = IDX_W'(1);
                addr_b_nxt = root_r[IDX_W-1:0];
              end else begin
                walk_nxt   = dec_walk;
                cur_nxt    = dec_entry;
                addr_a_nxt = dec_walk + 1'b1;
                addr_b_nxt = dec_entry[IDX_W-1:0];
              end
            end
          end
          PH_DESC: begin
            priority if (inq_op_r != OP_DESC) begin
              err = ERR_KIND;
            end else if (!inq_bit_r) begin
              err = ERR_NONE;
            end else if (tbl_full) begin
              err = ERR_TABLE;
            end else if (stk_stat.full) begin
              err = ERR_STACK;
            end else begin
              stk_ctl.push  = 1'b1;
              entry_cnt_nxt = ent_inc;
            end
          end
          PH_LEAF: begin
            priority if (inq_op_r != OP_LEAF) begin
              err = ERR_KIND;
            end else if (tbl_full) begin
              err = ERR_TABLE;
            end else begin
              leaf_wr       = 1'b1;
              entry_cnt_nxt = ent_inc;
              stk_ctl.pop   = !stk_stat.empty;
              pend_set      = !stk_stat.empty;
            end
          end
          default: begin
            priority if (inq_op_r != OP_DESC) begin
              err = ERR_KIND;
            end else if (inq_bit_r) begin
              err = ERR_TERM;
            end else begin
              walk_nxt   = '0;
              cur_nxt    = root_r;
              addr_a_nxt = IDX_W'(1);
              addr_b_nxt = root_r[IDX_W-1:0];
            end
          end
        endcase
      end
    end
  end

  // Leaf and start writes own the port; a popped branch write is registered and takes the port when neither writes.
  always_comb begin
    mem_we = 1'b1;
    mem_wa = pend_addr_r;
    mem_wd = pend_data_r;
    priority if (leaf_wr) begin
      mem_wa = entry_cnt_r[TAW-1:0];
      mem_wd = ENTRY_W'(inq_byte_r);
    end else if (start_wr) begin
      mem_wa = '0;
      mem_wd = '0;
    end else if (pend_valid_r) begin
      mem_wa = pend_addr_r;
      mem_wd = pend_data_r;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    priority if (pend_set) begin
      pend_valid_nxt = 1'b1;
    end else if (step && inq_op_r == OP_START) begin
      pend_valid_nxt = 1'b0;
    end else if (!leaf_wr && !start_wr) begin
      pend_valid_nxt = 1'b0;
    end else begin
      pend_valid_nxt = pend_valid_r;
    end
  end

  assign rng_a = (addr_a_nxt < IDX_W'(TABLE_ENTRIES));
  assign rng_b = (addr_b_nxt < IDX_W'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[mem_wa] <= mem_wd;
    end
    lchild_r <= rng_a ? tree_mem[addr_a_nxt[TAW-1:0]] : '0;
    rchild_r <= rng_b ? tree_mem[addr_b_nxt[TAW-1:0]] : '0;
    if (mem_we && mem_wa == '0) begin
      root_r <= mem_wd;
    end
    if (pend_set) begin
      pend_addr_r <= stk_stat.top[TAW-1:0];
      pend_data_r <= {1'b1, IDX_W'(ent_inc)};
    end
    walk_r   <= walk_nxt;
    cur_r    <= cur_nxt;
    addr_a_r <= addr_a_nxt;
    addr_b_r <= addr_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      entry_cnt_r  <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      entry_cnt_r  <= entry_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_sym_valid_r <= sym_valid;
      out_sym_r       <= sym;
      out_used_r      <= used;
      out_phase_r     <= phase_nxt;
      out_err_r       <= err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol_valid = out_sym_valid_r;
  assign out_symbol       = out_sym_r;
  assign out_bit_consumed = out_used_r;
  assign out_expect_res   = out_phase_r;
  assign out_error_code   = out_err_r;

endmodule

FILE: hw/rtl/huff8_stack.sv
// Branch index stack with a registered top-of-stack word.
module huff8_stack #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  huff8_pkg::stk_ctl_t  ctl,
  output huff8_pkg::stk_stat_t stat
);
  import huff8_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [IDX_W-1:0] stk_mem [DEPTH];
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [AW-1:0]    rd_addr;
  logic [IDX_W-1:0] top_r;

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Read the word that will be on top after this cycle.
  assign rd_addr = (count_nxt == '0) ? '0 : AW'(count_nxt - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stk_mem[count_r[AW-1:0]] <= ctl.push_idx;
    end
    // Forward a pushed index, the array still holds the old word this edge.
    top_r <= ctl.push ? ctl.push_idx : stk_mem[rd_addr];
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.top   = top_r;

endmodule

FILE: hw/rtl/huff8_checker.sv
// Port-level checks for the Huffman tree unit and their binding to the top level.
module huff8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_symbol_valid,
  input logic [7:0] out_symbol,
  input logic       out_bit_consumed,
  input logic [2:0] out_expect_res,
  input logic [2:0] out_error_code
);
  import huff8_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol)
      && $stable(out_error_code) && $stable(out_expect_res))
    else $error("result word changed under stall");

  // a decoded symbol only comes error-free while decoding
  a_sym_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol_valid |->
      out_error_code == ERR_NONE && out_expect_res == PH_CODE)
    else $error("symbol outside decode phase");

  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_symbol_valid |-> out_symbol == 8'd0 && !out_bit_consumed
      || out_valid && !out_symbol_valid && out_expect_res == PH_CODE
         && out_symbol == 8'd0)
    else $error("symbol field set without a symbol");

  // build errors drop back to waiting for a start word
  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_TERM || out_error_code == ERR_TABLE
      || out_error_code == ERR_STACK || out_error_code == ERR_NOTREE)
      |-> out_expect_res == PH_START)
    else $error("build error without return to start");

  // words in flight: an input held back means the output side is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind huffman8_tree_build_and_decode_unit huff8_checker u_huff8_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_symbol_valid (out_symbol_valid),
  .out_symbol       (out_symbol),
  .out_bit_consumed (out_bit_consumed),
  .out_expect_res   (out_expect_res),
  .out_error_code   (out_error_code)
);
